### rtl/csr_sparse_matvec_core_assert.svh
// assertion macros for the csr sparse matvec core
// depends on nothing; included by the modules that check their own logic
`ifndef CSR_SPARSE_MATVEC_CORE_ASSERT_SVH
`define CSR_SPARSE_MATVEC_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define CSRMV_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CSRMV_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CSRMV_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define CSRMV_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

### rtl/csrmv_pkg.sv
// shared constants, operation codes and the stage-one item type
// depends on nothing
package csrmv_pkg;

    localparam int unsigned VECTOR_DEPTH = 2048;
    localparam int unsigned VEC_AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
    localparam int unsigned OP_W = 2;
    localparam int unsigned POS_W = 11;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned SUM_W = 64;
    localparam int unsigned ROW_W = 16;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_ACCUM = 2'd1,
        OP_CLOSE = 2'd2
    } op_t;

    typedef struct packed {
        logic                     valid;
        op_t                      op;
        logic                     in_range;
        logic signed [DATA_W-1:0] matrix_value;
    } mac_item_t;

endpackage

### rtl/csrmv_vec_ram.sv
// single-port synchronous ram for the dense vector, registered read
// depends on nothing
module csrmv_vec_ram #(
    parameter int unsigned DEPTH = 2048,
    parameter int unsigned WIDTH = 32,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/csrmv_mac.sv
// multiply stage, row accumulator, row counter and result register
// depends on csrmv_pkg and csr_sparse_matvec_core_assert.svh
`include "csr_sparse_matvec_core_assert.svh"

module csrmv_mac import csrmv_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  mac_item_t                item,
    input  logic [DATA_W-1:0]        ram_q,
    output logic                     advance,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [SUM_W-1:0]  m_row_sum,
    output logic [ROW_W-1:0]         m_row_number
);

    logic                     s1_valid_reg;
    op_t                      s1_op_reg;
    logic                     s1_in_range_reg;
    logic signed [DATA_W-1:0] s1_mval_reg;
    logic signed [DATA_W-1:0] elem;
    logic signed [SUM_W-1:0]  prod;

    logic                     s2_valid_reg;
    op_t                      s2_op_reg;
    logic signed [SUM_W-1:0]  s2_prod_reg;

    logic [SUM_W-1:0] acc_reg, acc_next;
    logic [ROW_W-1:0] row_cnt_reg, row_cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic [SUM_W-1:0] out_sum_reg, out_sum_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic             stall;

    // a close at the end waits while the previous result is still held
    assign stall   = s2_valid_reg && (s2_op_reg == OP_CLOSE) && out_valid_reg && !m_ready;
    assign advance = !stall;

    // out-of-range columns read zero
    assign elem = (s1_in_range_reg && (s1_op_reg == OP_ACCUM)) ? $signed(ram_q) : '0;
    assign prod = s1_mval_reg * elem;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= item.valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_op_reg       <= item.op;
            s1_in_range_reg <= item.in_range;
            s1_mval_reg     <= item.matrix_value;
            s2_op_reg       <= s1_op_reg;
            s2_prod_reg     <= prod;
        end
    end

    always_comb begin
        acc_next       = acc_reg;
        row_cnt_next   = row_cnt_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_sum_next   = out_sum_reg;
        out_row_next   = out_row_reg;
        if (advance && s2_valid_reg) begin
            unique case (s2_op_reg)
                OP_ACCUM: begin
                    acc_next = acc_reg + SUM_W'(s2_prod_reg);
                end
                OP_CLOSE: begin
                    out_valid_next = 1'b1;
                    out_sum_next   = acc_reg;
                    out_row_next   = row_cnt_reg;
                    acc_next       = '0;
                    row_cnt_next   = ROW_W'(row_cnt_reg + 1'b1);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            row_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            acc_reg       <= acc_next;
            row_cnt_reg   <= row_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_sum_reg <= out_sum_next;
        out_row_reg <= out_row_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_row_sum    = $signed(out_sum_reg);
    assign m_row_number = out_row_reg;

    `CSRMV_ASSERT_IMP(a_stall_needs_result, aclk, aresetn, stall, out_valid_reg)
    `CSRMV_ASSERT_NXT(a_close_emits, aclk, aresetn,
        advance && s2_valid_reg && (s2_op_reg == OP_CLOSE), out_valid_reg && (acc_reg == '0))
    `CSRMV_ASSERT_NXT(a_row_steps, aclk, aresetn,
        advance && s2_valid_reg && (s2_op_reg == OP_CLOSE),
        row_cnt_reg == ROW_W'($past(row_cnt_reg) + 1'b1))
    `CSRMV_ASSERT_NXT(a_row_holds, aclk, aresetn,
        !(advance && s2_valid_reg && (s2_op_reg == OP_CLOSE)), $stable(row_cnt_reg))

endmodule

### rtl/csr_sparse_matvec_core.sv
// top level of the csr sparse matrix times dense vector core
// depends on csrmv_pkg, csrmv_vec_ram and csrmv_mac
//
// channel  direction  beat
// s_       in         operation, position, vector_value, matrix_value
// m_       out        row_sum, row_number (one beat per close-row)
//
// one beat accepted per cycle unless the pipeline stalls; a row result passes the stage-one,
// stage-two and result registers after its close-row; the vector ram port serves a load write
// or a nonzero read in the accept cycle; reset clears the accumulator, row counter and pipeline;
// the vector ram is not cleared; the pipeline stalls only when a close-row reaches the end while a result is not taken
module csr_sparse_matvec_core import csrmv_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [OP_W-1:0]          s_operation,
    input  logic [POS_W-1:0]         s_position,
    input  logic signed [DATA_W-1:0] s_vector_value,
    input  logic signed [DATA_W-1:0] s_matrix_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [SUM_W-1:0]  m_row_sum,
    output logic [ROW_W-1:0]         m_row_number
);

    logic              advance;
    logic              accept;
    logic              in_range;
    logic              is_load;
    logic              is_accum;
    logic              is_close;
    logic [DATA_W-1:0] ram_q;
    mac_item_t         item;

    assign s_ready  = advance;
    assign accept   = s_valid && s_ready;
    assign in_range = 32'(s_position) < VECTOR_DEPTH;
    assign is_load  = s_operation == OP_LOAD;
    assign is_accum = s_operation == OP_ACCUM;
    assign is_close = s_operation == OP_CLOSE;

    always_comb begin
        item.valid        = accept && (is_accum || is_close);
        item.op           = is_close ? OP_CLOSE : OP_ACCUM;
        item.in_range     = in_range;
        item.matrix_value = s_matrix_value;
    end

    csrmv_vec_ram #(
        .DEPTH (VECTOR_DEPTH),
        .WIDTH (DATA_W),
        .AW    (VEC_AW)
    ) u_vec_ram (
        .aclk  (aclk),
        .en    (accept && ((is_load && in_range) || is_accum)),
        .we    (is_load),
        .addr  (VEC_AW'(s_position)),
        .wdata (s_vector_value),
        .rdata (ram_q)
    );

    csrmv_mac u_mac (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item         (item),
        .ram_q        (ram_q),
        .advance      (advance),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_row_sum    (m_row_sum),
        .m_row_number (m_row_number)
    );

endmodule
